### design/assert_macros.svh
// Assertion macros used by the top level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on each clock edge outside reset.
`define FAD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on each clock edge, reset included.
`define FAD_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/fad_pkg.sv
// Constants and types for the face average downsampler.
package fad_pkg;

    localparam int MAX_COARSE_WIDTH_DEF = 1024;
    localparam int MAX_RATIO_DEF        = 16;
    localparam int SAMPLE_BITS_DEF      = 32;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 11;
    localparam int RATIO_CFG_W = 5;
    localparam int WIDTH_CFG_W = 11;
    localparam int ROW_W       = 16;
    localparam int DIGIT_BITS  = 4;

    typedef logic [CFG_INDEX_W-1:0] t_cfg_index;

    localparam t_cfg_index CFG_RATIO_X   = 2'd0;
    localparam t_cfg_index CFG_RATIO_Y   = 2'd1;
    localparam t_cfg_index CFG_DIRECTION = 2'd2;
    localparam t_cfg_index CFG_WIDTH     = 2'd3;

    localparam logic [RATIO_CFG_W-1:0] RATIO_RESET = 5'd2;
    localparam logic [WIDTH_CFG_W-1:0] WIDTH_RESET = 11'd1024;

endpackage

### design/fad_in_if.sv
// Input request channel: fine sample and frame start.
interface fad_in_if #(
    parameter int SAMPLE_BITS = fad_pkg::SAMPLE_BITS_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] fine_sample;
    logic                          frame_start;

    modport source (output valid, fine_sample, frame_start, input ready);
    modport sink   (input valid, fine_sample, frame_start, output ready);
endinterface

### design/fad_out_if.sv
// Output request channel: coarse value with its position.
interface fad_out_if #(
    parameter int SAMPLE_BITS = fad_pkg::SAMPLE_BITS_DEF,
    parameter int COL_W       = $clog2(fad_pkg::MAX_COARSE_WIDTH_DEF)
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] coarse_value;
    logic [COL_W-1:0]              coarse_col;
    logic [fad_pkg::ROW_W-1:0]     coarse_row;
    logic                          row_last;

    modport source (output valid, coarse_value, coarse_col, coarse_row, row_last, input ready);
    modport sink   (input valid, coarse_value, coarse_col, coarse_row, row_last, output ready);
endinterface

### design/fad_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module fad_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### design/fad_div.sv
// Signed divider by a small ratio, several quotient bits per cycle, truncating toward zero.
module fad_div #(
    parameter int ACC_BITS    = 36,
    parameter int SAMPLE_BITS = fad_pkg::SAMPLE_BITS_DEF,
    parameter int RAT_W       = 5
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [ACC_BITS-1:0]    i_dividend,
    input  logic [RAT_W-1:0]              i_divisor,
    output logic                          o_done,
    output logic signed [SAMPLE_BITS-1:0] o_quotient
);
    import fad_pkg::*;

    localparam int STEPS = (ACC_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int NB    = STEPS * DIGIT_BITS;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [NB-1:0]       r_work;
    logic [NB-1:0]       n_work;
    logic [RAT_W-1:0]    r_rem;
    logic [RAT_W-1:0]    n_rem;
    logic [RAT_W-1:0]    r_div;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_neg;
    logic                r_done;
    logic [ACC_BITS-1:0] mag;
    logic [SAMPLE_BITS-1:0] q;

    assign mag = i_dividend[ACC_BITS-1] ? (~i_dividend + ACC_BITS'(1)) : i_dividend;

    always_comb begin
        logic [RAT_W:0] rem_t;
        logic [NB-1:0]  work_t;
        logic [RAT_W-1:0] rem_v;
        work_t = r_work;
        rem_v  = r_rem;
        for (int k = 0; k < DIGIT_BITS; k++) begin
            rem_t  = {rem_v, work_t[NB-1]};
            work_t = {work_t[NB-2:0], 1'b0};
            if (rem_t >= {1'b0, r_div}) begin
                rem_t     = rem_t - {1'b0, r_div};
                work_t[0] = 1'b1;
            end
            rem_v = rem_t[RAT_W-1:0];
        end
        n_work = work_t;
        n_rem  = rem_v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= CNT_W'(STEPS);
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt  <= r_cnt - CNT_W'(1);
            r_done <= (r_cnt == CNT_W'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_work <= NB'(mag);
            r_rem  <= '0;
            r_div  <= i_divisor;
            r_neg  <= i_dividend[ACC_BITS-1];
        end else if (r_cnt != '0) begin
            r_work <= n_work;
            r_rem  <= n_rem;
        end
    end

    assign q          = r_work[SAMPLE_BITS-1:0];
    assign o_quotient = r_neg ? -q : q;
    assign o_done     = r_done;
endmodule

### design/face_average_downsampler.sv
// Top level of the face average downsampler.
// A sample that gives no result passes through accept and accumulate.
// A sample that closes an average passes through accept, accumulate, the
// 4-bit-per-cycle divider and the output register before its result shows.
// The input takes a new sample only once the last is through the read-modify-write
// of the column sum RAM; averaging samples hold the input for the divider and output stall too.
// Reset: synchronous, clears counters, run sum and config; column sums stay unset.
`include "assert_macros.svh"

module face_average_downsampler #(
    parameter int MAX_COARSE_WIDTH = fad_pkg::MAX_COARSE_WIDTH_DEF,
    parameter int MAX_RATIO        = fad_pkg::MAX_RATIO_DEF,
    parameter int SAMPLE_BITS      = fad_pkg::SAMPLE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [fad_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [fad_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    fad_in_if.sink                         i_in,
    fad_out_if.source                      o_out
);
    import fad_pkg::*;

    localparam int ACC_BITS = SAMPLE_BITS + $clog2(MAX_RATIO);
    localparam int PHASE_W  = $clog2(MAX_RATIO);
    localparam int RAT_W    = $clog2(MAX_RATIO + 1);
    localparam int COL_W    = $clog2(MAX_COARSE_WIDTH);
    localparam int CW_W     = $clog2(MAX_COARSE_WIDTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ACC  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [RATIO_CFG_W-1:0] r_ratio_x;
    logic [RATIO_CFG_W-1:0] r_ratio_y;
    logic                   r_dir;
    logic [WIDTH_CFG_W-1:0] r_width;

    logic [1:0]         r_state;
    logic [PHASE_W-1:0] r_fcp;
    logic [PHASE_W-1:0] r_frp;
    logic [COL_W-1:0]   r_ccc;
    logic [ROW_W-1:0]   r_crc;
    logic signed [ACC_BITS-1:0] r_run_sum;

    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic               r_first;
    logic               r_use;
    logic               r_emit;
    logic               r_dir0;
    logic [RAT_W-1:0]   r_div;
    logic [COL_W-1:0]   r_col;
    logic [ROW_W-1:0]   r_row;
    logic               r_row_last;
    logic signed [ACC_BITS-1:0] r_sum;
    logic               r_start;

    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_value;
    logic [COL_W-1:0]              r_out_col;
    logic [ROW_W-1:0]              r_out_row;
    logic                          r_out_last;

    logic [RAT_W-1:0]   rx;
    logic [RAT_W-1:0]   ry;
    logic [CW_W-1:0]    cw;
    logic               fs;
    logic [PHASE_W-1:0] c_fcp;
    logic [PHASE_W-1:0] c_frp;
    logic [COL_W-1:0]   c_ccc;
    logic [ROW_W-1:0]   c_crc;
    logic               fcp_zero;
    logic               frp_zero;
    logic               fcp_last;
    logic               frp_last;
    logic               col_last;
    logic               dir0;
    logic               in_fire;
    logic               out_load;
    logic               mem_we;
    logic [ACC_BITS-1:0] mem_rdata;
    logic signed [ACC_BITS-1:0] base;
    logic signed [ACC_BITS-1:0] acc_sum;
    logic               div_done;
    logic signed [SAMPLE_BITS-1:0] div_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio_x <= RATIO_RESET;
            r_ratio_y <= RATIO_RESET;
            r_dir     <= 1'b0;
            r_width   <= WIDTH_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_RATIO_X:   r_ratio_x <= i_cfg_data[RATIO_CFG_W-1:0];
                CFG_RATIO_Y:   r_ratio_y <= i_cfg_data[RATIO_CFG_W-1:0];
                CFG_DIRECTION: r_dir     <= i_cfg_data[0];
                CFG_WIDTH:     r_width   <= i_cfg_data[WIDTH_CFG_W-1:0];
                default:       ;
            endcase
        end
    end

    assign rx = (r_ratio_x == '0) ? RAT_W'(1) :
                ((int'(r_ratio_x) > MAX_RATIO) ? RAT_W'(MAX_RATIO) : RAT_W'(r_ratio_x));
    assign ry = (r_ratio_y == '0) ? RAT_W'(1) :
                ((int'(r_ratio_y) > MAX_RATIO) ? RAT_W'(MAX_RATIO) : RAT_W'(r_ratio_y));
    assign cw = (r_width == '0) ? CW_W'(1) :
                ((int'(r_width) > MAX_COARSE_WIDTH) ? CW_W'(MAX_COARSE_WIDTH) : CW_W'(r_width));

    assign fs    = i_in.frame_start;
    assign c_fcp = (fs || RAT_W'(r_fcp) >= rx) ? '0 : r_fcp;
    assign c_frp = (fs || RAT_W'(r_frp) >= ry) ? '0 : r_frp;
    assign c_ccc = (fs || CW_W'(r_ccc) >= cw) ? '0 : r_ccc;
    assign c_crc = fs ? '0 : r_crc;

    assign fcp_zero = (c_fcp == '0);
    assign frp_zero = (c_frp == '0);
    assign fcp_last = (RAT_W'(c_fcp) == rx - RAT_W'(1));
    assign frp_last = (RAT_W'(c_frp) == ry - RAT_W'(1));
    assign col_last = (CW_W'(c_ccc) == cw - CW_W'(1));
    assign dir0     = !r_dir;

    assign i_in.ready = (r_state == S_IDLE);
    assign in_fire    = i_in.valid && i_in.ready;
    assign out_load   = (r_state == S_OUT) && (!r_out_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fcp     <= '0;
            r_frp     <= '0;
            r_ccc     <= '0;
            r_crc     <= '0;
            r_run_sum <= '0;
            r_start   <= 1'b0;
        end else begin
            r_start <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_state <= S_ACC;
                        if (fs) begin
                            r_run_sum <= '0;
                        end
                        r_fcp <= fcp_last ? '0 : c_fcp + PHASE_W'(1);
                        r_ccc <= fcp_last ? (col_last ? '0 : c_ccc + COL_W'(1)) : c_ccc;
                        r_frp <= (fcp_last && col_last) ?
                                 (frp_last ? '0 : c_frp + PHASE_W'(1)) : c_frp;
                        r_crc <= (fcp_last && col_last && frp_last) ?
                                 c_crc + ROW_W'(1) : c_crc;
                    end
                end
                S_ACC: begin
                    if (r_use && !r_dir0) begin
                        r_run_sum <= acc_sum;
                    end
                    if (r_emit) begin
                        r_state <= S_DIV;
                        r_start <= 1'b1;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_sample   <= i_in.fine_sample;
            r_dir0     <= dir0;
            r_use      <= dir0 ? fcp_zero : frp_zero;
            r_first    <= dir0 ? frp_zero : fcp_zero;
            r_emit     <= dir0 ? (fcp_zero && frp_last) : (frp_zero && fcp_last);
            r_div      <= dir0 ? ry : rx;
            r_col      <= c_ccc;
            r_row      <= c_crc;
            r_row_last <= col_last;
        end
        if (r_state == S_ACC) begin
            r_sum <= acc_sum;
        end
    end

    assign base    = r_first ? '0 : (r_dir0 ? $signed(mem_rdata) : r_run_sum);
    assign acc_sum = base + ACC_BITS'(r_sample);
    assign mem_we  = (r_state == S_ACC) && r_use && r_dir0;

    fad_ram #(
        .WIDTH (ACC_BITS),
        .DEPTH (MAX_COARSE_WIDTH)
    ) u_column_sums (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_col),
        .i_wdata (acc_sum),
        .i_re    (in_fire),
        .i_raddr (c_ccc),
        .o_rdata (mem_rdata)
    );

    fad_div #(
        .ACC_BITS    (ACC_BITS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .RAT_W       (RAT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_start),
        .i_dividend (r_sum),
        .i_divisor  (r_div),
        .o_done     (div_done),
        .o_quotient (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_value <= div_quot;
            r_out_col   <= r_col;
            r_out_row   <= r_row;
            r_out_last  <= r_row_last;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.coarse_value = r_out_value;
    assign o_out.coarse_col   = r_out_col;
    assign o_out.coarse_row   = r_out_row;
    assign o_out.row_last     = r_out_last;

    `FAD_ASSERT(a_acc_follows_accept, i_clk, i_rst_n, (r_state == S_ACC) |-> ($past(r_state) == S_IDLE && $past(i_in.valid)), "accumulate without accepted request")
    `FAD_ASSERT(a_div_only_on_emit, i_clk, i_rst_n, (r_state == S_DIV && $past(r_state) == S_ACC) |-> $past(r_emit), "divide entered without a closing sample")
    `FAD_ASSERT(a_done_in_div, i_clk, i_rst_n, div_done |-> (r_state == S_DIV), "divider finished outside divide state")
    `FAD_ASSERT(a_out_from_load, i_clk, i_rst_n, $rose(o_out.valid) |-> ($past(r_state) == S_OUT), "result shown without a finished average")
    `FAD_ASSERT_RST(a_reset_idle, i_clk, !i_rst_n |=> (r_state == S_IDLE && !o_out.valid), "reset did not clear control state")
endmodule
